// ===== design/ehe_pkg.sv =====
// shared types, constants and register map of the echo hiding embedder
package ehe_pkg;

	localparam int DEF_MAX_DELAY = 4096;
	localparam int DEF_MSG_BYTES = 64;
	localparam int QDEPTH = 4;
	localparam int MAX_CHANNELS = 8;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [2:0] REG_DELAY_ZERO = 3'd0;
	localparam logic [2:0] REG_DELAY_ONE  = 3'd1;
	localparam logic [2:0] REG_SEGMENT    = 3'd2;
	localparam logic [2:0] REG_DECAY      = 3'd3;
	localparam logic [2:0] REG_CHANNELS   = 3'd4;

	localparam logic [11:0] RST_DELAY_ZERO = 12'd100;
	localparam logic [11:0] RST_DELAY_ONE  = 12'd200;
	localparam logic [12:0] RST_SEGMENT    = 13'd300;
	localparam logic [14:0] RST_DECAY      = 15'd16384;
	localparam logic [3:0]  RST_CHANNELS   = 4'd2;

	typedef struct packed {
		logic               op;
		logic signed [15:0] sample_in;
		logic [7:0]         message_byte;
	} in_word_t;

	typedef struct packed {
		logic signed [15:0] sample_out;
		logic               echo_added;
		logic               current_bit;
	} out_word_t;

	typedef struct packed {
		logic [11:0] delay_zero_frames;
		logic [11:0] delay_one_frames;
		logic [12:0] segment_frames;
		logic [14:0] decay_gain;
		logic [3:0]  channel_count;
	} cfg_t;

	// one classified sample on its way to the echo datapath
	typedef struct packed {
		logic signed [15:0] sample;
		logic signed [15:0] past;
		logic               add;
		logic               msg_bit;
	} q_entry_t;

endpackage

// ===== design/ehe_ram.sv =====
// generic single write port ram with registered read
module ehe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== design/ehe_front.sv =====
// front end: accepts words, keeps message and frame state, reads the echo history
module ehe_front
	import ehe_pkg::*;
#(
	parameter int MAX_DELAY = DEF_MAX_DELAY,
	parameter int MSG_BYTES = DEF_MSG_BYTES
) (
	input  logic     clk,
	input  logic     arst_n,
	input  cfg_t     cfg,
	input  logic     item_valid,
	output logic     item_ready,
	input  in_word_t item,
	output logic     q_push,
	output q_entry_t q_entry,
	input  logic     q_full
);
	localparam int HA_W = $clog2(MAX_DELAY);
	localparam int MA_W = MSG_BYTES > 1 ? $clog2(MSG_BYTES) : 1;
	localparam int LEN_W = $clog2(MSG_BYTES + 1);
	localparam int BP_W = LEN_W + 3;
	localparam int XW = (HA_W > 13 ? HA_W : 13) + 1;

	logic [HA_W-1:0]  ptr_q;
	logic [12:0]      off_q;
	logic [2:0]       ci_q;
	logic [LEN_W-1:0] len_q;
	logic [BP_W-1:0]  bp_q;

	logic               s1_valid_q;
	logic signed [15:0] x_s1;
	logic [2:0]         sel_s1;
	logic               have_s1;
	logic               ok0_s1;
	logic               ok1_s1;

	logic               acc, acc_smp, acc_ld;
	logic [3:0]         chans;
	logic [3:0]         ci_inc;
	logic               frame_end;
	logic [12:0]        seg;
	logic [13:0]        off_inc;
	logic               seg_end;
	logic               have_bit;
	logic               ch0;
	logic [XW-1:0]      d0_x, d1_x, off_x;
	logic [HA_W-1:0]    d0c, d1c, slot0, slot1;
	logic [HA_W:0]      wrap0, wrap1;
	logic               ok0, ok1;
	logic [15:0]        h0_rd, h1_rd;
	logic [7:0]         byte_rd;
	logic               msg_bit;

	assign acc     = item_valid && item_ready;
	assign acc_smp = acc && (item.op == OP_SAMPLE);
	assign acc_ld  = acc && (item.op == OP_LOAD);

	assign item_ready = !s1_valid_q || !q_full;
	assign q_push     = s1_valid_q && !q_full;

	always_comb begin
		if (cfg.channel_count == 4'd0) begin
			chans = 4'd1;
		end else if (cfg.channel_count > 4'(MAX_CHANNELS)) begin
			chans = 4'(MAX_CHANNELS);
		end else begin
			chans = cfg.channel_count;
		end
	end

	assign ci_inc    = {1'b0, ci_q} + 4'd1;
	// a lowered channel count ends the frame on the next sample
	assign frame_end = ci_inc >= chans;
	assign seg       = (cfg.segment_frames == 13'd0) ? 13'd1 : cfg.segment_frames;
	assign off_inc   = {1'b0, off_q} + 14'd1;
	assign seg_end   = off_inc >= {1'b0, seg};
	assign have_bit  = bp_q < {len_q, 3'b000};
	assign ch0       = ci_q == 3'd0;

	// delays clamp to the history depth
	always_comb begin
		d0_x = XW'(cfg.delay_zero_frames);
		d1_x = XW'(cfg.delay_one_frames);
		if (d0_x >= XW'(MAX_DELAY)) begin
			d0_x = XW'(MAX_DELAY - 1);
		end
		if (d1_x >= XW'(MAX_DELAY)) begin
			d1_x = XW'(MAX_DELAY - 1);
		end
	end

	assign d0c   = d0_x[HA_W-1:0];
	assign d1c   = d1_x[HA_W-1:0];
	assign off_x = XW'(off_q);
	assign ok0   = ch0 && have_bit && (d0_x != '0) && (off_x >= d0_x);
	assign ok1   = ch0 && have_bit && (d1_x != '0) && (off_x >= d1_x);

	assign wrap0 = {1'b0, ptr_q} + (HA_W+1)'(MAX_DELAY) - {1'b0, d0c};
	assign wrap1 = {1'b0, ptr_q} + (HA_W+1)'(MAX_DELAY) - {1'b0, d1c};
	assign slot0 = (ptr_q >= d0c) ? ptr_q - d0c : wrap0[HA_W-1:0];
	assign slot1 = (ptr_q >= d1c) ? ptr_q - d1c : wrap1[HA_W-1:0];

	// one history copy per candidate delay, the bit picks one from the registered read data
	ehe_ram #(.WIDTH(16), .DEPTH(MAX_DELAY)) u_hist0 (
		.clk   (clk),
		.we    (acc_smp && ch0),
		.waddr (ptr_q),
		.wdata (item.sample_in),
		.re    (acc_smp),
		.raddr (slot0),
		.rdata (h0_rd)
	);

	ehe_ram #(.WIDTH(16), .DEPTH(MAX_DELAY)) u_hist1 (
		.clk   (clk),
		.we    (acc_smp && ch0),
		.waddr (ptr_q),
		.wdata (item.sample_in),
		.re    (acc_smp),
		.raddr (slot1),
		.rdata (h1_rd)
	);

	ehe_ram #(.WIDTH(8), .DEPTH(MSG_BYTES)) u_msg (
		.clk   (clk),
		.we    (acc_ld && (len_q < LEN_W'(MSG_BYTES))),
		.waddr (len_q[MA_W-1:0]),
		.wdata (item.message_byte),
		.re    (acc_smp),
		.raddr (bp_q[MA_W+2:3]),
		.rdata (byte_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q      <= '0;
			off_q      <= '0;
			ci_q       <= '0;
			len_q      <= '0;
			bp_q       <= '0;
			s1_valid_q <= 1'b0;
		end else begin
			if (acc_ld && (len_q < LEN_W'(MSG_BYTES))) begin
				len_q <= len_q + LEN_W'(1);
			end
			if (acc_smp) begin
				if (ch0) begin
					ptr_q <= (ptr_q == HA_W'(MAX_DELAY - 1)) ? '0 : ptr_q + HA_W'(1);
				end
				if (frame_end) begin
					ci_q <= '0;
					if (seg_end) begin
						off_q <= '0;
						if (have_bit) begin
							bp_q <= bp_q + BP_W'(1);
						end
					end else begin
						off_q <= off_inc[12:0];
					end
				end else begin
					ci_q <= ci_inc[2:0];
				end
			end
			if (acc_smp) begin
				s1_valid_q <= 1'b1;
			end else if (q_push) begin
				s1_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_smp) begin
			x_s1    <= item.sample_in;
			sel_s1  <= bp_q[2:0];
			have_s1 <= have_bit;
			ok0_s1  <= ok0;
			ok1_s1  <= ok1;
		end
	end

	// msb first within each byte
	assign msg_bit = have_s1 && byte_rd[3'd7 - sel_s1];

	always_comb begin
		q_entry.sample  = x_s1;
		q_entry.past    = msg_bit ? h1_rd : h0_rd;
		q_entry.add     = msg_bit ? ok1_s1 : ok0_s1;
		q_entry.msg_bit = msg_bit;
	end

`ifndef SYNTHESIS
	a_slot_not_written: assert property (@(posedge clk) disable iff (!arst_n)
		acc_smp |-> (!ok0 || (slot0 != ptr_q)) && (!ok1 || (slot1 != ptr_q)))
		else $error("history read collides with write");
	a_ram_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !q_push) |=> $stable(h0_rd) && $stable(h1_rd) && $stable(byte_rd))
		else $error("stalled word lost its ram data");
	a_bits_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(bp_q <= {len_q, 3'b000}) && (len_q <= LEN_W'(MSG_BYTES)))
		else $error("bit position past loaded message");
`endif
endmodule

// ===== design/ehe_queue.sv =====
// short queue between the front end and the echo datapath
module ehe_queue
	import ehe_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  q_entry_t wr_entry,
	output logic     full,
	output logic     valid,
	output q_entry_t head,
	input  logic     pop
);
	localparam int P_W = $clog2(QDEPTH);
	localparam int C_W = $clog2(QDEPTH + 1);

	q_entry_t       entries [QDEPTH];
	logic [P_W-1:0] wp_q;
	logic [P_W-1:0] rp_q;
	logic [C_W-1:0] count_q;
	logic           do_push, do_pop;

	assign full    = count_q == C_W'(QDEPTH);
	assign valid   = count_q != '0;
	assign head    = entries[rp_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				wp_q <= (wp_q == P_W'(QDEPTH - 1)) ? '0 : wp_q + P_W'(1);
			end
			if (do_pop) begin
				rp_q <= (rp_q == P_W'(QDEPTH - 1)) ? '0 : rp_q + P_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + C_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - C_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries[wp_q] <= wr_entry;
		end
	end

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= C_W'(QDEPTH))
		else $error("queue count overflow");
	a_count_up: assert property (@(posedge clk) disable iff (!arst_n)
		(do_push && !do_pop) |=> count_q == $past(count_q) + C_W'(1))
		else $error("queue lost a push");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (wp_q == rp_q))
		else $error("empty queue with split pointers");
`endif
endmodule

// ===== design/ehe_back.sv =====
// echo datapath: gain multiply, rounding, saturating add and output register
module ehe_back
	import ehe_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic [14:0] decay_gain,
	input  logic        q_valid,
	input  q_entry_t    q_head,
	output logic        q_pop,
	output logic        result_valid,
	input  logic        result_ready,
	output out_word_t   result
);
	logic               s2_valid_q;
	logic signed [31:0] prod_s2;
	logic signed [15:0] x_s2;
	logic               add_s2;
	logic               bit_s2;

	logic               out_valid_q;
	out_word_t          out_q;

	logic               out_load;
	logic               s2_load;
	logic signed [31:0] rounded;
	logic signed [16:0] term;
	logic signed [17:0] sum;
	logic signed [15:0] y;

	assign out_load = !out_valid_q || result_ready;
	assign s2_load  = !s2_valid_q || out_load;
	assign q_pop    = q_valid && s2_load;

	// q0.15 product rounded to nearest, ties up
	assign rounded = prod_s2 + 32'sd16384;
	assign term    = 17'(rounded >>> 15);
	assign sum     = 18'(x_s2) + 18'(term);

	always_comb begin
		if (!add_s2) begin
			y = x_s2;
		end else if (sum > 18'sd32767) begin
			y = 16'sh7fff;
		end else if (sum < -18'sd32768) begin
			y = -16'sh8000;
		end else begin
			y = sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_load) begin
				s2_valid_q <= q_valid;
			end
			if (out_load) begin
				out_valid_q <= s2_valid_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			prod_s2 <= 32'($signed({1'b0, decay_gain})) * 32'(q_head.past);
			x_s2    <= q_head.sample;
			add_s2  <= q_head.add;
			bit_s2  <= q_head.msg_bit;
		end
		if (out_load && s2_valid_q) begin
			out_q.sample_out  <= y;
			out_q.echo_added  <= add_s2;
			out_q.current_bit <= bit_s2;
		end
	end

	assign result_valid = out_valid_q;
	assign result       = out_q;
endmodule

// ===== design/echo_hiding_embedder.sv =====
// top level of the echo hiding embedder with its register block
//
//  channel   signals                                   direction  notes
//  item      item_valid item_ready item                in         message byte or audio word
//  result    result_valid result_ready result          out        one word per audio sample
//  regs      psel penable pwrite paddr pwdata prdata   in/out     apb, pready tied high
//
// one word a cycle when not stalled; front end and echo datapath each take one word a cycle
// an audio word moves through the front end stage, queue, product stage and output register
// byte loads give no result; they write the message ram and its length until the ram is full
// arst_n resets all control state and the registers; ram contents are undefined until written
// a full queue stalls the front end, a stalled output stalls the datapath on its own
module echo_hiding_embedder
	import ehe_pkg::*;
#(
	parameter int MAX_DELAY = DEF_MAX_DELAY,
	parameter int MSG_BYTES = DEF_MSG_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_ready,
	input  in_word_t    item,
	output logic        result_valid,
	input  logic        result_ready,
	output out_word_t   result,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	cfg_t     cfg_q;
	logic     q_push, q_full, q_valid, q_pop;
	q_entry_t q_wr, q_head;
	logic     reg_wr;

	assign pready = 1'b1;
	assign reg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delay_zero_frames <= RST_DELAY_ZERO;
			cfg_q.delay_one_frames  <= RST_DELAY_ONE;
			cfg_q.segment_frames    <= RST_SEGMENT;
			cfg_q.decay_gain        <= RST_DECAY;
			cfg_q.channel_count     <= RST_CHANNELS;
		end else if (reg_wr) begin
			unique case (paddr[4:2])
				REG_DELAY_ZERO: cfg_q.delay_zero_frames <= pwdata[11:0];
				REG_DELAY_ONE:  cfg_q.delay_one_frames  <= pwdata[11:0];
				REG_SEGMENT:    cfg_q.segment_frames    <= pwdata[12:0];
				REG_DECAY:      cfg_q.decay_gain        <= pwdata[14:0];
				REG_CHANNELS:   cfg_q.channel_count     <= pwdata[3:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[4:2])
			REG_DELAY_ZERO: prdata = 32'(cfg_q.delay_zero_frames);
			REG_DELAY_ONE:  prdata = 32'(cfg_q.delay_one_frames);
			REG_SEGMENT:    prdata = 32'(cfg_q.segment_frames);
			REG_DECAY:      prdata = 32'(cfg_q.decay_gain);
			REG_CHANNELS:   prdata = 32'(cfg_q.channel_count);
			default:        prdata = '0;
		endcase
	end

	ehe_front #(.MAX_DELAY(MAX_DELAY), .MSG_BYTES(MSG_BYTES)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.q_push     (q_push),
		.q_entry    (q_wr),
		.q_full     (q_full)
	);

	ehe_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wr_entry (q_wr),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head),
		.pop      (q_pop)
	);

	ehe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.decay_gain   (cfg_q.decay_gain),
		.q_valid      (q_valid),
		.q_head       (q_head),
		.q_pop        (q_pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);
endmodule

// ===== tb/sv/tb_top.sv =====
// self-checking testbench of the echo hiding embedder
`timescale 1ns / 100ps

module tb_top;
	import ehe_pkg::*;

	localparam int QUIET_LIMIT = 4000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        item_valid = 1'b0;
	logic        item_ready;
	in_word_t    item = '0;
	logic        result_valid;
	logic        result_ready = 1'b0;
	out_word_t   result;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	echo_hiding_embedder uut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_ready(item_ready), .item(item),
		.result_valid(result_valid), .result_ready(result_ready), .result(result),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// expected embedder state
	logic [11:0]        cfg_dz, cfg_do;
	logic [12:0]        cfg_seg;
	logic [14:0]        cfg_gain;
	logic [3:0]         cfg_chans;
	logic signed [15:0] hist [0:DEF_MAX_DELAY-1];
	logic [11:0]        hist_wr;
	logic [12:0]        seg_pos;
	logic [2:0]         chan_idx;
	logic [7:0]         msg_mem [0:DEF_MSG_BYTES-1];
	logic [6:0]         msg_len;
	int                 bit_idx;

	in_word_t  stream_q [$];
	out_word_t embedded_q [$];
	out_word_t due;
	int        words_queued = 0;
	int        words_taken = 0;
	int        bad_count = 0;
	int        gap_left = 0;
	int        stall_left = 0;
	int        stall_draw;
	int        quiet_cycles = 0;
	logic      tx_pace = 1'b1;
	logic      rx_pace = 1'b1;

	int tone [0:19] = '{32767, -32768, 32767, 32767, -32768, -32768, 1, -1, -1, 1,
		0, -32768, 32767, 0, -2, 2, 16384, -16384, 12345, -12345};

	function automatic void flag(string what);
		bad_count++;
		if (bad_count <= 10) $display("mismatch: %s", what);
	endfunction

	function automatic void embed_sample(in_word_t w);
		int chans, seg, d, g, p, y, nxt, slot;
		logic [7:0] cur_byte;
		logic cur_bit, has_bit;
		out_word_t o;
		if (w.op == OP_LOAD) begin
			// loads past the end of the store are dropped
			if (msg_len < DEF_MSG_BYTES) begin
				msg_mem[msg_len] = w.message_byte;
				msg_len = msg_len + 1'b1;
			end
			return;
		end
		chans = (cfg_chans == 0) ? 1 : ((cfg_chans > MAX_CHANNELS) ? MAX_CHANNELS : cfg_chans);
		seg = (cfg_seg == 0) ? 1 : cfg_seg;
		y = $signed(w.sample_in);
		cur_bit = 1'b0;
		has_bit = bit_idx < int'(msg_len) * 8;
		if (has_bit) begin
			cur_byte = msg_mem[(bit_idx >> 3) % DEF_MSG_BYTES];
			cur_bit = cur_byte[7 - (bit_idx & 7)];
		end
		o.echo_added = 1'b0;
		if (chan_idx == 0) begin
			if (has_bit) begin
				d = cur_bit ? cfg_do : cfg_dz;
				if (d >= DEF_MAX_DELAY) d = DEF_MAX_DELAY - 1;
				if (d != 0 && seg_pos >= d) begin
					slot = (hist_wr + DEF_MAX_DELAY - d) % DEF_MAX_DELAY;
					g = cfg_gain;
					p = hist[slot];
					// q0.15 product, rounded half up
					y = y + ((g * p + 16384) >>> 15);
					if (y > 32767) y = 32767;
					if (y < -32768) y = -32768;
					o.echo_added = 1'b1;
				end
			end
			hist[hist_wr] = w.sample_in;
			hist_wr = hist_wr + 1'b1;
		end
		nxt = chan_idx + 1;
		if (nxt >= chans) begin
			chan_idx = '0;
			nxt = seg_pos + 1;
			if (nxt >= seg) begin
				seg_pos = '0;
				if (has_bit) bit_idx++;
			end else begin
				seg_pos = nxt;
			end
		end else begin
			chan_idx = nxt;
		end
		o.sample_out = y[15:0];
		o.current_bit = cur_bit;
		embedded_q.insert(embedded_q.size(), o);
	endfunction

	function automatic void queue_audio(logic signed [15:0] x);
		in_word_t w;
		w.op = OP_SAMPLE;
		w.sample_in = x;
		w.message_byte = $urandom;
		stream_q.insert(stream_q.size(), w);
		words_queued++;
	endfunction

	function automatic void queue_load(logic [7:0] v);
		in_word_t w;
		w.op = OP_LOAD;
		w.sample_in = $urandom;
		w.message_byte = v;
		stream_q.insert(stream_q.size(), w);
		words_queued++;
	endfunction

	function automatic logic signed [15:0] rand_pcm();
		case ($urandom_range(0, 7))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] rand_char();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hFF;
			default: return $urandom;
		endcase
	endfunction

	task automatic reg_write(logic [2:0] idx, logic [31:0] val);
		logic [31:0] mask;
		case (idx)
			REG_DELAY_ZERO, REG_DELAY_ONE: mask = 32'hFFF;
			REG_SEGMENT: mask = 32'h1FFF;
			REG_DECAY: mask = 32'h7FFF;
			default: mask = 32'hF;
		endcase
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		case (idx)
			REG_DELAY_ZERO: cfg_dz = val[11:0];
			REG_DELAY_ONE: cfg_do = val[11:0];
			REG_SEGMENT: cfg_seg = val[12:0];
			REG_DECAY: cfg_gain = val[14:0];
			REG_CHANNELS: cfg_chans = val[3:0];
			default: ;
		endcase
		// read back through the same address
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if ((prdata & mask) !== (val & mask))
			flag($sformatf("reg %0d read exp %h got %h", idx, val & mask, prdata & mask));
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		while (words_taken != words_queued || embedded_q.size() != 0) @(posedge clk);
		// byte loads have no result and may still be in the pipe
		repeat (8) @(posedge clk);
	endtask

	// sender
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid <= 1'b0;
			item <= '0;
			gap_left <= 0;
		end else begin
			if (item_valid && item_ready) begin
				embed_sample(item);
				words_taken++;
			end
			if (item_valid && !item_ready) begin
				item_valid <= 1'b1;
			end else if (gap_left != 0) begin
				item_valid <= 1'b0;
				gap_left <= gap_left - 1;
			end else if (stream_q.size() != 0) begin
				item <= stream_q.pop_front();
				item_valid <= 1'b1;
				gap_left <= tx_pace ? $urandom_range(0, 15) : 0;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_ready <= 1'b0;
			stall_left <= 0;
		end else begin
			if (result_valid && result_ready) begin
				if (embedded_q.size() == 0) begin
					flag($sformatf("unexpected word sample %0d echo %b bit %b",
						result.sample_out, result.echo_added, result.current_bit));
				end else begin
					due = embedded_q.pop_front();
					if (result.sample_out !== due.sample_out || result.echo_added !== due.echo_added
						|| result.current_bit !== due.current_bit)
						flag($sformatf("exp %0d/%b/%b got %0d/%b/%b",
							due.sample_out, due.echo_added, due.current_bit,
							result.sample_out, result.echo_added, result.current_bit));
				end
				stall_draw = rx_pace ? $urandom_range(0, 15) : 0;
				stall_left <= stall_draw;
				result_ready <= (stall_draw == 0);
			end else if (stall_left != 0) begin
				stall_left <= stall_left - 1;
				result_ready <= (stall_left == 1);
			end else begin
				result_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (item_valid && item_ready) || (result_valid && result_ready)
			|| (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= QUIET_LIMIT);
		$display("tb: failure");
		$finish;
	end

	initial begin
		int i, n, kind, load_pct, loads, seg_v, dz_v, do_v, chans_v, gain_v;
		cfg_dz = RST_DELAY_ZERO;
		cfg_do = RST_DELAY_ONE;
		cfg_seg = RST_SEGMENT;
		cfg_gain = RST_DECAY;
		cfg_chans = RST_CHANNELS;
		for (i = 0; i < DEF_MAX_DELAY; i++) hist[i] = '0;
		for (i = 0; i < DEF_MSG_BYTES; i++) msg_mem[i] = '0;
		hist_wr = '0;
		seg_pos = '0;
		chan_idx = '0;
		msg_len = '0;
		bit_idx = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: pass-through with no message, one byte at two frames a bit, full gain
		reg_write(REG_DELAY_ZERO, 1);
		reg_write(REG_DELAY_ONE, 1);
		reg_write(REG_SEGMENT, 2);
		reg_write(REG_DECAY, 32767);
		reg_write(REG_CHANNELS, 1);
		for (i = 0; i < 20; i++) begin
			if (i == 2) queue_load(8'hA5);
			queue_audio(tone[i]);
		end
		loads = 1;
		settle();

		while (words_queued < 740) begin
			kind = $urandom_range(0, 7);
			if (kind == 0) begin
				case ($urandom_range(0, 3))
					0: seg_v = 0;
					1: seg_v = 1;
					2: seg_v = 2;
					default: seg_v = 8191;
				endcase
				case ($urandom_range(0, 2))
					0: dz_v = 0;
					1: dz_v = 1;
					default: dz_v = 4095;
				endcase
				case ($urandom_range(0, 2))
					0: do_v = 0;
					1: do_v = 1;
					default: do_v = 4095;
				endcase
				gain_v = $urandom_range(0, 1) ? 32767 : 0;
				case ($urandom_range(0, 4))
					0: chans_v = 0;
					1: chans_v = 1;
					2: chans_v = 8;
					3: chans_v = 9;
					default: chans_v = 15;
				endcase
			end else begin
				seg_v = ($urandom_range(0, 3) == 0) ? $urandom_range(11, 48) : $urandom_range(2, 10);
				dz_v = $urandom_range(0, seg_v + 2);
				do_v = $urandom_range(0, seg_v + 2);
				gain_v = $urandom_range(0, 32767);
				chans_v = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 15) : $urandom_range(1, 3);
			end
			// upper bits beyond the delay-zero field are junk and must be dropped
			reg_write(REG_DELAY_ZERO, {$urandom_range(0, 1) ? 20'hFFFFF : 20'h0, dz_v[11:0]});
			reg_write(REG_DELAY_ONE, do_v);
			reg_write(REG_SEGMENT, seg_v);
			reg_write(REG_DECAY, gain_v);
			reg_write(REG_CHANNELS, chans_v);
			tx_pace = ($urandom_range(0, 3) != 0);
			rx_pace = ($urandom_range(0, 3) != 0);
			case ($urandom_range(0, 2))
				0: load_pct = 0;
				1: load_pct = 3;
				default: load_pct = 10;
			endcase
			n = $urandom_range(20, 90);
			repeat (n) begin
				if (loads < 60 && $urandom_range(0, 99) < load_pct) begin
					queue_load(rand_char());
					loads++;
				end else begin
					queue_audio(rand_pcm());
				end
			end
			settle();
		end

		// fill the store past its end, samples in between
		reg_write(REG_SEGMENT, 2);
		reg_write(REG_CHANNELS, 2);
		reg_write(REG_DELAY_ZERO, 1);
		tx_pace = 1'b1;
		rx_pace = 1'b1;
		while (loads < 70) begin
			queue_load(rand_char());
			loads++;
			repeat ($urandom_range(0, 2)) queue_audio(rand_pcm());
		end
		repeat (20) queue_audio(rand_pcm());
		settle();
		repeat (16) @(posedge clk);

		if (bad_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

// ===== echo_hiding_embedder.f =====
design/ehe_pkg.sv
design/ehe_ram.sv
design/ehe_front.sv
design/ehe_queue.sv
design/ehe_back.sv
design/echo_hiding_embedder.sv
tb/sv/tb_top.sv
